// ===== rtl/pct4d_pkg.sv =====
// Shared types, register codes and reset values for the pixel-constant 4D transform.
// Used by the register file, controller, datapath and top level; depends on nothing.
`default_nettype none

package pct4d_pkg;

    localparam int PCT_COMPONENT_WIDTH = 24;
    localparam int PCT_ITERATION_WIDTH = 8;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam int EST_W  = 32;
    localparam int LANE_W = 16;

    typedef enum logic [2:0] {
        REG_START      = 3'd0,
        REG_STOP       = 3'd1,
        REG_MODE       = 3'd2,
        REG_OFFSET     = 3'd3,
        REG_SCALE      = 3'd4,
        REG_EST_SCALE  = 3'd5,
        REG_EST_OFFSET = 3'd6
    } t_reg_idx;

    localparam int MODE_RADIUS    = 0;
    localparam int MODE_QUADRAY   = 1;
    localparam int MODE_ABS_PRE   = 2;
    localparam int MODE_ABS_POST  = 3;
    localparam int MODE_MIRROR    = 4;
    localparam int MODE_ADD       = 5;

    localparam logic [7:0]  RST_START      = 8'd0;
    localparam logic [7:0]  RST_STOP       = 8'd1;
    localparam logic [5:0]  RST_MODE       = 6'd0;
    localparam logic [63:0] RST_OFFSET     = 64'h0;
    localparam logic [63:0] RST_SCALE      = 64'h1000_1000_1000_1000;
    localparam logic [31:0] RST_EST_SCALE  = 32'h0001_0000;
    localparam logic [31:0] RST_EST_OFFSET = 32'h0;

    typedef struct packed {
        logic [7:0]  start_iter;
        logic [7:0]  stop_iter;
        logic [5:0]  mode;
        logic [63:0] offset;
        logic [63:0] scale;
        logic [31:0] est_scale;
        logic [31:0] est_offset;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       sq_step;
        logic [1:0] sq_idx;
        logic       root_init;
        logic       root_step;
        logic       mix;
        logic       offset;
        logic       scale;
        logic       round;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic in_window;
        logic use_radius;
        logic out_stall;
    } t_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_ROOT,
        ST_MIX,
        ST_OFFSET,
        ST_SCALE,
        ST_ROUND,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/pct4d_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on pct4d_pkg for register codes, reset values and the t_cfg struct.
`default_nettype none

module pct4d_regs import pct4d_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_iter <= RST_START;
            r_cfg.stop_iter  <= RST_STOP;
            r_cfg.mode       <= RST_MODE;
            r_cfg.offset     <= RST_OFFSET;
            r_cfg.scale      <= RST_SCALE;
            r_cfg.est_scale  <= RST_EST_SCALE;
            r_cfg.est_offset <= RST_EST_OFFSET;
        end else if (wr_en) begin
            case (idx)
                REG_START:      r_cfg.start_iter <= pwdata[7:0];
                REG_STOP:       r_cfg.stop_iter  <= pwdata[7:0];
                REG_MODE:       r_cfg.mode       <= pwdata[5:0];
                REG_OFFSET:     r_cfg.offset     <= pwdata;
                REG_SCALE:      r_cfg.scale      <= pwdata;
                REG_EST_SCALE:  r_cfg.est_scale  <= pwdata[31:0];
                REG_EST_OFFSET: r_cfg.est_offset <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START:      prdata = APB_DW'(r_cfg.start_iter);
            REG_STOP:       prdata = APB_DW'(r_cfg.stop_iter);
            REG_MODE:       prdata = APB_DW'(r_cfg.mode);
            REG_OFFSET:     prdata = r_cfg.offset;
            REG_SCALE:      prdata = r_cfg.scale;
            REG_EST_SCALE:  prdata = APB_DW'(r_cfg.est_scale);
            REG_EST_OFFSET: prdata = APB_DW'(r_cfg.est_offset);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pct4d_ctrl.sv =====
// Controller state machine: sequences capture, squaring, root, reshape and finish steps.
// Depends on pct4d_pkg for t_state, t_cmd and t_sts.
`default_nettype none

module pct4d_ctrl import pct4d_pkg::*; #(
    parameter int COMPONENT_WIDTH = PCT_COMPONENT_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    localparam int CNTW = $clog2(COMPONENT_WIDTH + 1);

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_cnt = '0;
                if (i_sts.in_window && i_sts.use_radius) begin
                    n_state = ST_SQUARE;
                end else if (i_sts.in_window) begin
                    n_state = ST_MIX;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SQUARE: begin
                o_cmd.sq_step = 1'b1;
                o_cmd.sq_idx  = r_cnt[1:0];
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt   = '0;
                    n_state = ST_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                if (r_cnt == '0) begin
                    o_cmd.root_init = 1'b1;
                end else begin
                    o_cmd.root_step = 1'b1;
                end
                if (r_cnt == CNTW'(COMPONENT_WIDTH)) begin
                    n_cnt   = '0;
                    n_state = ST_MIX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_OFFSET;
            end
            ST_OFFSET: begin
                o_cmd.offset = 1'b1;
                n_state      = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_sts.out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pct4d_dp.sv =====
// Datapath: pixel constant and working copy, squaring and root unit, reshape lanes,
// estimate multiplier and the output register. Depends on pct4d_pkg.
`default_nettype none

module pct4d_dp import pct4d_pkg::*; #(
    parameter int COMPONENT_WIDTH = PCT_COMPONENT_WIDTH,
    parameter int ITERATION_WIDTH = PCT_ITERATION_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  t_cfg                                        i_cfg,
    input  t_cmd                                        i_cmd,
    output t_sts                                        o_sts,
    input  wire logic                                   i_start_pixel,
    input  wire logic [ITERATION_WIDTH-1:0]             i_iteration,
    input  wire logic [3:0][COMPONENT_WIDTH-1:0]        i_pixel,
    input  wire logic [3:0][COMPONENT_WIDTH-1:0]        i_point,
    input  wire logic [EST_W-1:0]                       i_estimate,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output logic      [3:0][COMPONENT_WIDTH-1:0]        o_new,
    output logic      [EST_W-1:0]                       o_estimate
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int IW = ITERATION_WIDTH;
    localparam int XW = CW + 6;
    localparam int SW = 2 * CW;
    localparam int PW = CW + LANE_W;

    logic [3:0][CW-1:0] r_pc, r_wc, r_pt, r_t, r_new;
    logic [3:0][PW-1:0] r_prod;
    logic [IW-1:0]      r_it;
    logic [EST_W-1:0]   r_est_in, r_est_out;
    logic [63:0]        r_est_prod;
    logic [SW-1:0]      r_sq, r_sum, r_rad, r_root, r_bit;
    logic               r_out_valid;

    function automatic logic [XW-1:0] sx(input logic [CW-1:0] v);
        return {{(XW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic [CW-1:0] sat(input logic [XW-1:0] v);
        logic fits;
        fits = (v[XW-1:CW-1] == {(XW-CW+1){v[XW-1]}});
        if (fits) begin
            return v[CW-1:0];
        end else if (v[XW-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    function automatic logic [CW-1:0] neg(input logic [CW-1:0] v);
        return sat({XW{1'b0}} - sx(v));
    endfunction

    function automatic logic [CW-1:0] absv(input logic [CW-1:0] v);
        return v[CW-1] ? neg(v) : v;
    endfunction

    logic [IW+7:0] start_x, stop_x;
    logic [IW-1:0] start_c, stop_c;

    assign start_x = {{IW{1'b0}}, i_cfg.start_iter};
    assign stop_x  = {{IW{1'b0}}, i_cfg.stop_iter};
    assign start_c = start_x[IW-1:0];
    assign stop_c  = stop_x[IW-1:0];

    assign o_sts.in_window  = (r_it >= start_c) && (r_it < stop_c);
    assign o_sts.use_radius = i_cfg.mode[MODE_RADIUS];
    assign o_sts.out_stall  = r_out_valid & ~i_out_ready;

    // squaring and root
    logic [CW-1:0] mag;
    logic [SW-1:0] sq_v, n_rad, n_root, root_half;
    logic [SW:0]   trial;
    logic          ge;
    logic [CW-1:0] root_sat;

    always_comb begin
        mag       = r_pc[i_cmd.sq_idx][CW-1] ? (~r_pc[i_cmd.sq_idx] + 1'b1)
                                             : r_pc[i_cmd.sq_idx];
        sq_v      = mag * mag;
        trial     = {1'b0, r_root} + {1'b0, r_bit};
        ge        = {1'b0, r_rad} >= trial;
        root_half = r_root >> 1;
        n_rad     = ge ? (r_rad - trial[SW-1:0]) : r_rad;
        n_root    = ge ? (root_half + r_bit) : root_half;
        root_sat  = (r_root[SW-1:CW-1] != '0) ? {1'b0, {(CW-1){1'b1}}} : r_root[CW-1:0];
    end

    // reshape lanes
    logic [3:0][CW-1:0] a_v, q_v, mix_t, off_t, rnd_t, fin_w, fin_z;
    logic [3:0][PW-1:0] prod_t;
    logic [XW-1:0]      off_ext;
    logic [PW:0]        rnd_s;
    logic [15:0]        off_l, scl_l;
    logic signed [PW-1:0] prod_s;

    always_comb begin
        a_v = r_pc;
        if (i_cfg.mode[MODE_RADIUS]) begin
            a_v[3] = root_sat;
        end
        q_v[0] = sat(sx(a_v[0]) + sx(a_v[1]) + sx(a_v[2]));
        q_v[1] = sat(sx(a_v[2]) - sx(a_v[0]) - sx(a_v[1]));
        q_v[2] = sat(sx(a_v[1]) - sx(a_v[0]) - sx(a_v[2]));
        q_v[3] = sat(sx(a_v[0]) - sx(a_v[1]) - sx(a_v[2]));
        off_ext = '0;
        rnd_s   = '0;
        off_l   = '0;
        scl_l   = '0;
        prod_s  = '0;
        for (int k = 0; k < 4; k++) begin
            mix_t[k] = i_cfg.mode[MODE_QUADRAY] ? q_v[k] : a_v[k];
            if (i_cfg.mode[MODE_ABS_PRE]) begin
                mix_t[k] = absv(mix_t[k]);
            end
            off_l    = i_cfg.offset[16*k +: 16];
            off_ext  = {{(XW-20){off_l[15]}}, off_l, 4'b0000};
            off_t[k] = sat(sx(r_t[k]) - off_ext);
            if (i_cfg.mode[MODE_ABS_POST]) begin
                off_t[k] = absv(off_t[k]);
            end
            scl_l     = i_cfg.scale[16*k +: 16];
            prod_s    = $signed(r_t[k]) * $signed(scl_l);
            prod_t[k] = prod_s;
            rnd_s     = {r_prod[k][PW-1], r_prod[k]} + (PW+1)'(2048);
            rnd_t[k]  = sat({rnd_s[PW], rnd_s[PW:12]});
            fin_w[k]  = r_wc[k];
            if (i_cfg.mode[MODE_MIRROR]) begin
                if (r_pt[k] == '0) begin
                    fin_w[k] = '0;
                end else if (r_pt[k][CW-1]) begin
                    fin_w[k] = neg(r_wc[k]);
                end
            end
            fin_z[k] = r_pt[k];
            if (i_cfg.mode[MODE_ADD]) begin
                fin_z[k] = sat(sx(r_pt[k]) + sx(fin_w[k]));
            end
        end
    end

    // distance estimate
    logic signed [63:0] est_prod_s;
    logic [63:0]        est_rnd;
    logic [48:0]        est_sum;
    logic [EST_W-1:0]   est_res;

    always_comb begin
        est_prod_s = $signed(r_est_in) * $signed(i_cfg.est_scale);
        est_rnd    = r_est_prod + 64'd32768;
        est_sum    = {est_rnd[63], est_rnd[63:16]}
                   + {{17{i_cfg.est_offset[31]}}, i_cfg.est_offset};
        if (est_sum[48:31] == {18{est_sum[48]}}) begin
            est_res = est_sum[31:0];
        end else if (est_sum[48]) begin
            est_res = 32'h8000_0000;
        end else begin
            est_res = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_est_prod <= est_prod_s;
        if (i_cmd.capture) begin
            r_it     <= i_iteration;
            r_pt     <= i_point;
            r_est_in <= i_estimate;
        end
        if (i_cmd.sq_step) begin
            r_sq  <= sq_v;
            r_sum <= (i_cmd.sq_idx == 2'd0) ? '0 : (r_sum + r_sq);
        end
        if (i_cmd.root_init) begin
            r_rad  <= r_sum;
            r_root <= '0;
            r_bit  <= {2'b01, {(SW-2){1'b0}}};
        end else if (i_cmd.root_step) begin
            r_rad  <= n_rad;
            r_root <= n_root;
            r_bit  <= r_bit >> 2;
        end
        if (i_cmd.mix) begin
            r_t <= mix_t;
        end else if (i_cmd.offset) begin
            r_t <= off_t;
        end
        if (i_cmd.scale) begin
            r_prod <= prod_t;
        end
        if (i_cmd.finish) begin
            r_new     <= fin_z;
            r_est_out <= est_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_wc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture && i_start_pixel) begin
                r_pc <= i_pixel;
                r_wc <= i_pixel;
            end else if (i_cmd.round) begin
                r_pc <= rnd_t;
                r_wc <= rnd_t;
            end else if (i_cmd.finish) begin
                r_wc <= fin_w;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new       = r_new;
    assign o_estimate  = r_est_out;

endmodule

`default_nettype wire

// ===== rtl/pixel_constant_4d_transform.sv =====
// Top level of the pixel-constant 4D transform: APB registers, controller and datapath.
// Depends on pct4d_pkg, pct4d_regs, pct4d_ctrl and pct4d_dp.
//
// Usage:
//   s_* stream: one transaction per fractal step. s_tuser carries start_pixel, which
//   loads the pixel point into the stored constant and working copy before the step.
//   m_* stream: one transaction per accepted input, the updated point and estimate.
//   APB port: seven registers at byte addresses 0, 8, ..., 48; write them only while
//   the block is idle.
// Steps:
//   Outside the iteration window an item goes through accept, decide and finish.
//   Inside the window it also goes through mix, offset, scale and round, and when
//   the xyz length goes into w, through the single squaring multiplier, one component
//   at a time, and the shift-subtract root unit, one root bit per cycle.
//   One item is in work at a time; the result leaves through an output register, and
//   the next item is accepted while that result still waits.
// Reset: synchronous, active low; registers return to their defaults, the stored
//   constants clear to zero and no result is pending.
// Stall: while m_tready is low the result holds; the following item then waits in
//   its finish step until the output register frees.
`default_nettype none

module pixel_constant_4d_transform import pct4d_pkg::*; #(
    parameter int COMPONENT_WIDTH = PCT_COMPONENT_WIDTH,
    parameter int ITERATION_WIDTH = PCT_ITERATION_WIDTH,
    localparam int IN_BITS  = ITERATION_WIDTH + 8 * COMPONENT_WIDTH + EST_W,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 4 * COMPONENT_WIDTH + EST_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // iteration, pixel_x, pixel_y, pixel_z, pixel_w, point_x, point_y, point_z,
    // point_w, estimate_in, zero fill
    input  wire logic [IN_W-1:0]   s_tdata,
    // start_pixel
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // new_x, new_y, new_z, new_w, estimate_out, zero fill
    output logic      [OUT_W-1:0]  m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int IW = ITERATION_WIDTH;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    logic [3:0][CW-1:0] pixel, point, new_pt;
    logic [EST_W-1:0]   est_in, est_out;

    for (genvar k = 0; k < 4; k++) begin : g_unpack
        assign pixel[k] = s_tdata[IW + k*CW +: CW];
        assign point[k] = s_tdata[IW + (4+k)*CW +: CW];
    end
    assign est_in  = s_tdata[IW + 8*CW +: EST_W];
    assign m_tdata = OUT_W'({est_out, new_pt});

    pct4d_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pct4d_ctrl #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pct4d_dp #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .ITERATION_WIDTH (ITERATION_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_start_pixel (s_tuser),
        .i_iteration   (s_tdata[IW-1:0]),
        .i_pixel       (pixel),
        .i_point       (point),
        .i_estimate    (est_in),
        .i_out_ready   (m_tready),
        .o_out_valid   (m_tvalid),
        .o_new         (new_pt),
        .o_estimate    (est_out)
    );

endmodule

`default_nettype wire

// ===== rtl/pct4d_checker.sv =====
// Port-level checks for the pixel-constant 4D transform, bound to the top level.
// Depends on the top level's handshake ports only.
`default_nettype none

module pct4d_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without an item in work");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && s_tready))
        else $error("reset left a result or a busy input");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port wait state");

endmodule

bind pixel_constant_4d_transform pct4d_checker u_pct4d_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pready   (pready)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for pixel_constant_4d_transform: a behavioural predictor of the
// constant reshaping, sign mirror, add and estimate update checks every result transaction.
// Depends on pct4d_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench import pct4d_pkg::*;;

    localparam int CW = PCT_COMPONENT_WIDTH;
    localparam int IN_W = 8 + 8 * CW + EST_W;
    localparam int OUT_W = 4 * CW + EST_W;
    localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint EMAX = 64'sd2147483647;
    localparam longint EMIN = -64'sd2147483648;
    localparam logic [CW-1:0] C_MAXV = CW'(CMAX);
    localparam logic [CW-1:0] C_MINV = CW'(CMIN);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic                   start;
        logic [7:0]             iter;
        logic [3:0][CW-1:0]     pix;
        logic [3:0][CW-1:0]     pt;
        logic [EST_W-1:0]       est;
    } t_step_item;

    typedef struct packed {
        logic [EST_W-1:0]       est;
        logic [3:0][CW-1:0]     comp;
    } t_step_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    t_cfg cfg_model;
    longint pix_const [4];
    longint work_const [4];
    t_step_result pending_results [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit back_to_back = 1'b0;
    bit hold_pending = 1'b0;

    pixel_constant_4d_transform dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint clamp_comp(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint mag_comp(longint v);
        return clamp_comp(v < 0 ? -v : v);
    endfunction

    function automatic longint lane_of(logic [63:0] vec, int k);
        return longint'($signed(vec[16*k +: 16]));
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_step_result transform_step(t_step_item it);
        longint t [4];
        longint q [4];
        longint z [4];
        longint de;
        longint r;
        longint unsigned sq;
        t_step_result res;
        for (int k = 0; k < 4; k++) z[k] = longint'($signed(it.pt[k]));
        if (it.start) begin
            for (int k = 0; k < 4; k++) begin
                pix_const[k] = longint'($signed(it.pix[k]));
                work_const[k] = pix_const[k];
            end
        end
        if (it.iter >= cfg_model.start_iter && it.iter < cfg_model.stop_iter) begin
            for (int k = 0; k < 4; k++) t[k] = pix_const[k];
            if (cfg_model.mode[MODE_RADIUS]) begin
                sq = 0;
                for (int k = 0; k < 3; k++) sq += longint'(t[k] * t[k]);
                sq = root_floor(sq);
                t[3] = (sq > longint'(CMAX)) ? CMAX : longint'(sq);
            end
            if (cfg_model.mode[MODE_QUADRAY]) begin
                q[0] = clamp_comp(t[0] + t[1] + t[2]);
                q[1] = clamp_comp(-t[0] - t[1] + t[2]);
                q[2] = clamp_comp(-t[0] + t[1] - t[2]);
                q[3] = clamp_comp(t[0] - t[1] - t[2]);
                for (int k = 0; k < 4; k++) t[k] = q[k];
            end
            for (int k = 0; k < 4; k++) begin
                if (cfg_model.mode[MODE_ABS_PRE]) t[k] = mag_comp(t[k]);
                t[k] = clamp_comp(t[k] - lane_of(cfg_model.offset, k) * 16);
                if (cfg_model.mode[MODE_ABS_POST]) t[k] = mag_comp(t[k]);
                t[k] = clamp_comp((t[k] * lane_of(cfg_model.scale, k) + 2048) >>> 12);
                pix_const[k] = t[k];
                work_const[k] = t[k];
            end
        end
        if (cfg_model.mode[MODE_MIRROR]) begin
            for (int k = 0; k < 4; k++) begin
                if (z[k] == 0) work_const[k] = 0;
                else if (z[k] < 0) work_const[k] = clamp_comp(-work_const[k]);
            end
        end
        if (cfg_model.mode[MODE_ADD]) begin
            for (int k = 0; k < 4; k++) z[k] = clamp_comp(z[k] + work_const[k]);
        end
        for (int k = 0; k < 4; k++) res.comp[k] = CW'(z[k]);
        de = longint'($signed(it.est));
        r = ((de * longint'($signed(cfg_model.est_scale)) + 32768) >>> 16)
            + longint'($signed(cfg_model.est_offset));
        if (r > EMAX) r = EMAX;
        if (r < EMIN) r = EMIN;
        res.est = EST_W'(r);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_step_result exp_res;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (m_tdata[CW*k +: CW] !== exp_res.comp[k]) begin
                        $display("%0t: component %0d expected %h actual %h", $time, k,
                                 exp_res.comp[k], m_tdata[CW*k +: CW]);
                        mismatch_count++;
                    end
                end
                if (m_tdata[4*CW +: EST_W] !== exp_res.est) begin
                    $display("%0t: estimate expected %h actual %h", $time, exp_res.est,
                             m_tdata[4*CW +: EST_W]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int seg_left;
        int seg_kind;
        int hold_left;
        m_tready = 1'b0;
        seg_left = 0;
        seg_kind = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_left = 400;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 40);
                    seg_kind = $urandom_range(0, 3);
                end
                seg_left--;
                case (seg_kind)
                    2: m_tready <= 1'($urandom_range(0, 1));
                    3: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return C_MAXV;
            2: return C_MINV;
            3, 4, 5: return CW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return 16'h1000;
            5: return 16'(int'($urandom_range(0, 16'h2000)) - 16'h1000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_est();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_step_item make_item(logic start, logic [7:0] iter);
        t_step_item it;
        it.start = start;
        it.iter = iter;
        for (int k = 0; k < 4; k++) begin
            it.pix[k] = rand_comp();
            it.pt[k] = rand_comp();
        end
        it.est = rand_est();
        return it;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_START:      cfg_model.start_iter = value[7:0];
            REG_STOP:       cfg_model.stop_iter = value[7:0];
            REG_MODE:       cfg_model.mode = value[5:0];
            REG_OFFSET:     cfg_model.offset = value;
            REG_SCALE:      cfg_model.scale = value;
            REG_EST_SCALE:  cfg_model.est_scale = value[31:0];
            REG_EST_OFFSET: cfg_model.est_offset = value[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(t_step_item it);
        int gap;
        if (!back_to_back && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= it.start;
        s_tdata <= {it.est, it.pt, it.pix, it.iter};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_results.push_back(transform_step(it));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_defaults();
        t_step_item it;
        it = make_item(1'b1, 8'd0);
        it.pix = {4{C_MAXV}};
        it.pt = {C_MINV, C_MAXV, CW'(0), C_MINV};
        it.est = 32'h7FFF_FFFF;
        send_item(it);
        it = make_item(1'b0, 8'd1);
        it.est = 32'h8000_0000;
        send_item(it);
        send_item(make_item(1'b0, 8'd0));
        send_item(make_item(1'b1, 8'd255));
    endtask

    task automatic test_each_mode();
        logic [CW-1:0] pix_pat [4];
        logic [CW-1:0] pt_pat [4];
        logic [31:0] est_pat [4];
        t_step_item it;
        pix_pat = '{C_MINV, C_MAXV, CW'(0), CW'(24'h010000)};
        pt_pat = '{CW'(0), C_MINV, C_MAXV, CW'(24'hFF0000)};
        est_pat = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000};
        wait_idle();
        write_reg(REG_START, 64'd0);
        write_reg(REG_STOP, 64'd255);
        write_reg(REG_OFFSET, 64'h8000_7FFF_0001_FFFF);
        write_reg(REG_SCALE, 64'h8000_7FFF_F000_1000);
        for (int b = 0; b < 7; b++) begin
            wait_idle();
            write_reg(REG_MODE, (b < 6) ? (64'd1 << b) : 64'h3F);
            write_reg(REG_EST_SCALE, {32'd0, est_pat[b % 4]});
            write_reg(REG_EST_OFFSET, {32'd0, est_pat[(b + 1) % 4]});
            it = make_item(1'b1, 8'd0);
            for (int k = 0; k < 4; k++) begin
                it.pix[k] = (b == 0) ? C_MINV : pix_pat[(k + b) % 4];
                it.pt[k] = pt_pat[(k + b) % 4];
            end
            it.est = est_pat[(b + 2) % 4];
            send_item(it);
            it = make_item(1'b0, 8'd1);
            for (int k = 0; k < 4; k++) it.pt[k] = pt_pat[(k + b + 1) % 4];
            send_item(it);
        end
    endtask

    task automatic test_window_edges();
        wait_idle();
        write_reg(REG_MODE, 64'd0);
        write_reg(REG_START, 64'd3);
        write_reg(REG_STOP, 64'd6);
        send_item(make_item(1'b1, 8'd2));
        send_item(make_item(1'b0, 8'd3));
        send_item(make_item(1'b0, 8'd5));
        send_item(make_item(1'b0, 8'd6));
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_MODE, 64'h3F);
        write_reg(REG_START, 64'd0);
        write_reg(REG_STOP, 64'd255);
        back_to_back = 1'b1;
        hold_pending = 1'b1;
        for (int n = 0; n < 24; n++) send_item(make_item(n % 6 == 0, 8'(n % 6)));
        back_to_back = 1'b0;
    endtask

    task automatic test_random();
        int start_it;
        int stop_it;
        int len;
        int n;
        logic [7:0] first;
        logic [5:0] mode;
        t_step_item it;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            start_it = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 255);
            stop_it = ($urandom_range(0, 9) < 7) ? start_it + $urandom_range(0, 12)
                                                 : $urandom_range(0, 255);
            if (stop_it > 255) stop_it = 255;
            mode = 6'($urandom_range(0, 63));
            case (phase)
                0: begin start_it = 0; stop_it = 255; end
                1: begin start_it = 255; stop_it = 255; end
                2: mode = 6'h3F;
                3: mode = 6'h00;
                4: begin start_it = 200; stop_it = 100; end
                default: ;
            endcase
            wait_idle();
            write_reg(REG_START, 64'(start_it));
            write_reg(REG_STOP, 64'(stop_it));
            write_reg(REG_MODE, 64'(mode));
            write_reg(REG_OFFSET, {rand_lane(), rand_lane(), rand_lane(), rand_lane()});
            write_reg(REG_SCALE, {rand_lane(), rand_lane(), rand_lane(), rand_lane()});
            write_reg(REG_EST_SCALE, {32'd0, rand_est()});
            write_reg(REG_EST_OFFSET, {32'd0, rand_est()});
            n = 0;
            while (n < PHASE_ITEMS) begin
                len = $urandom_range(1, 12);
                first = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
                for (int j = 0; j < len; j++) begin
                    it = make_item(j == 0, first + 8'(j));
                    if ($urandom_range(0, 9) == 0) begin
                        it.start = 1'($urandom_range(0, 1));
                        it.iter = 8'($urandom);
                    end
                    send_item(it);
                    n++;
                end
            end
        end
    endtask

    initial begin
        cfg_model.start_iter = RST_START;
        cfg_model.stop_iter = RST_STOP;
        cfg_model.mode = RST_MODE;
        cfg_model.offset = RST_OFFSET;
        cfg_model.scale = RST_SCALE;
        cfg_model.est_scale = RST_EST_SCALE;
        cfg_model.est_offset = RST_EST_OFFSET;
        for (int k = 0; k < 4; k++) begin
            pix_const[k] = 0;
            work_const[k] = 0;
        end
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_defaults();
        test_each_mode();
        test_window_edges();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
